// ===== src/sklfsr_pkg.sv =====
// Shared constants, types and functions of the seed-to-key LFSR block.
package sklfsr_pkg;

    localparam int SEED_W      = 24;
    localparam int KEY_W       = 24;
    localparam int LFSR_W      = 24;
    localparam int MASK_W      = 40;
    localparam int CHAL_W      = 64;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 40;
    localparam int BITS_PER_CELL = 8;
    localparam int NUM_CELLS   = CHAL_W / BITS_PER_CELL;

    localparam logic [LFSR_W-1:0] TAP_BITS = 24'h109028;
    localparam logic [MASK_W-1:0] MASK_RESET = 40'hFF_FFFF_FFFF;
    localparam logic [LFSR_W-1:0] INIT_RESET = 24'hC541A9;

    localparam logic [CFG_IDX_W-1:0] REG_CHALLENGE_MASK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE     = 8'd1;

    typedef struct packed {
        logic [LFSR_W-1:0] r;
        logic [CHAL_W-1:0] chal;
    } sklfsr_work_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] r,
                                                      input logic chal_bit);
        logic                in_bit;
        logic [LFSR_W-1:0]   nxt;
        in_bit = chal_bit ^ r[0];
        nxt = {in_bit, r[LFSR_W-1:1]};
        if (in_bit)
        begin
            nxt = nxt ^ TAP_BITS;
        end
        return nxt;
    endfunction

    function automatic logic [KEY_W-1:0] shuffle(input logic [LFSR_W-1:0] r);
        return {r[11:4], r[15:12], r[23:20], r[3:0], r[19:16]};
    endfunction

endpackage

// ===== src/seed_key_lfsr_24.sv =====
// Top level of the seed-to-key block: configuration registers and the cell chain.
//
// A seed request is accepted on a rising edge with in_valid high and in_stall low.
// The key request for it appears on out_valid/key and is taken on an edge with
// out_stall low. The block holds a chain of eight cells; each cell runs eight
// steps of the 24-bit shift register on one byte of the 64-bit challenge, and a
// key is offered once its request has passed through the registers of all
// eight cells in order.
// With out_stall low the block takes one seed every cycle.
// When the receiver stalls, the key stays on the port unchanged and requests
// still in flight move up into empty cells; in_stall rises only once every cell
// holds a request.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0 is
// the 40-bit challenge mask, index 1 the 24-bit start value; other indexes are
// ignored. Writes must be made only while no request is in flight; the block
// does not enforce it. Reset clears all cells and loads the mask with all ones
// and the start value with 0xC541A9.
module seed_key_lfsr_24
    import sklfsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SEED_W-1:0]     seed,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_W-1:0]      key
);

    logic [MASK_W-1:0] mask_reg;
    logic [LFSR_W-1:0] init_reg;

    logic         valid [0:NUM_CELLS];
    logic         ready [0:NUM_CELLS];
    sklfsr_work_t data  [0:NUM_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= MASK_RESET;
            init_reg <= INIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHALLENGE_MASK: mask_reg <= cfg_data[MASK_W-1:0];
                REG_INIT_VALUE:     init_reg <= cfg_data[LFSR_W-1:0];
                default:            ;
            endcase
        end
    end

    assign valid[0]     = in_valid;
    assign in_stall     = !ready[0];
    assign data[0].r    = init_reg;
    assign data[0].chal = {mask_reg[7:0], mask_reg[15:8], mask_reg[23:16],
                           mask_reg[31:24], mask_reg[39:32],
                           seed[7:0], seed[15:8], seed[23:16]};

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        sklfsr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid[g]),
            .up_ready (ready[g]),
            .up_data  (data[g]),
            .dn_valid (valid[g+1]),
            .dn_ready (ready[g+1]),
            .dn_data  (data[g+1])
        );
    end

    assign ready[NUM_CELLS] = !out_stall;
    assign out_valid        = valid[NUM_CELLS];
    assign key              = shuffle(data[NUM_CELLS].r);

endmodule

// ===== src/sklfsr_cell.sv =====
// One pipeline cell that runs eight LFSR steps on the low challenge byte.
module sklfsr_cell
    import sklfsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_ready,
    input  sklfsr_work_t up_data,
    output logic         dn_valid,
    input  logic         dn_ready,
    output sklfsr_work_t dn_data
);

    logic         valid_reg;
    logic         valid_next;
    sklfsr_work_t data_reg;
    sklfsr_work_t data_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        logic [LFSR_W-1:0] r;
        r = up_data.r;
        for (int i = 0; i < BITS_PER_CELL; i++)
        begin
            r = lfsr_step(r, up_data.chal[i]);
        end
        data_next.r = r;
        data_next.chal = up_data.chal >> BITS_PER_CELL;
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== src/sklfsr_check.sv =====
// Port-level assertions for the seed-to-key block and their bind.
module sklfsr_check
    import sklfsr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [KEY_W-1:0]  key
);

    // A stalled key request stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key))
        else $error("stalled key request changed");

    // With the receiver ready, every cell can advance, so the input never stalls.
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // The input stalls only behind a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // An input stall with the receiver stalled is seen only while a result is pending.
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall && out_stall |=> $past(out_valid))
        else $error("stall seen without a pending result");

endmodule

bind seed_key_lfsr_24 sklfsr_check u_sklfsr_check (.*);
